[design/zsfd_pkg.sv]
package zsfd_pkg;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_HEADER,
        PH_ROW,
        PH_END,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        KIND_HIT,
        KIND_OK,
        KIND_BAD_START,
        KIND_BAD_HEADER,
        KIND_WRONG_COLUMN,
        KIND_BAD_END,
        KIND_TRUNCATED
    } kind_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_PARSE,
        C_TRUNC,
        C_FLUSH
    } ctrl_state_t;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 22;
    localparam logic [CFG_IDX_W-1:0] REG_START_PATTERN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_PATTERN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_PATTERN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_MASK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SHIFT = 3'd4;

    localparam int WORD_W = 32;
    localparam int REM_W = 6;
    localparam int PIX_W = 22;
    localparam int COL_W = 4;
    localparam int ROW_W = 7;
    localparam int SHIFT_W = 5;
    localparam logic [1:0] MAX_HITS = 2'd2;

    typedef struct packed {
        kind_t              kind;
        logic [COL_W-1:0]   column;
        logic [ROW_W-1:0]   row;
        logic [PIX_W-1:0]   pixel_word;
    } result_t;

    typedef struct packed {
        logic load;
        logic step;
        logic trunc;
        logic flush;
    } zsfd_cmd_t;

    typedef struct packed {
        logic parse_done;
        logic res_gen;
        logic trunc_gen;
        logic pend_valid;
        logic out_free;
    } zsfd_status_t;

endpackage

[design/zsfd_ctrl.sv]
module zsfd_ctrl
    import zsfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  zsfd_status_t st,
    output zsfd_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            C_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = C_PARSE;
                end
            end
            C_PARSE:
            begin
                if (st.parse_done)
                begin
                    state_next = C_TRUNC;
                end
                else if (!(st.res_gen && st.pend_valid && !st.out_free))
                begin
                    cmd.step = 1'b1;
                end
            end
            C_TRUNC:
            begin
                if (!st.trunc_gen)
                begin
                    state_next = C_FLUSH;
                end
                else if (!(st.pend_valid && !st.out_free))
                begin
                    cmd.trunc = 1'b1;
                    state_next = C_FLUSH;
                end
            end
            C_FLUSH:
            begin
                if (!st.pend_valid)
                begin
                    state_next = C_IDLE;
                end
                else if (st.out_free)
                begin
                    cmd.flush = 1'b1;
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    // A result may only be pushed into the pending slot when the slot can drain.
    a_no_push_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step && st.res_gen && st.pend_valid |-> st.out_free)
        else $error("step pushed a result into a busy output");
    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == C_PARSE)
        else $error("load did not start parsing");
    a_flush_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |=> state_reg == C_IDLE)
        else $error("flush did not return to idle");

endmodule

[design/zsfd_datapath.sv]
module zsfd_datapath
    import zsfd_pkg::*;
#(
    parameter int NUM_COLUMNS = 16,
    parameter int NUM_ROWS = 128,
    parameter int TOKEN_BITS = 22
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [WORD_W-1:0]     word_data,
    input  logic                  frame_first,
    input  logic                  frame_last,
    input  zsfd_cmd_t             cmd,
    output zsfd_status_t          st,
    input  logic                  out_stall,
    output logic                  out_valid,
    output result_t               out_res,
    output logic                  out_last
);

    localparam int CARRY_W = TOKEN_BITS - 1;
    localparam int CCNT_W = $clog2(TOKEN_BITS);
    localparam int CAT_W = CARRY_W + WORD_W;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(NUM_COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(NUM_ROWS - 1);
    localparam logic [WORD_W-1:0] TOK_MASK = WORD_W'((64'd1 << TOKEN_BITS) - 64'd1);

    logic [PIX_W-1:0]   start_reg, end_reg, hpat_reg, hmask_reg;
    logic [SHIFT_W-1:0] hshift_reg;

    logic [WORD_W-1:0]  word_reg, word_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [CARRY_W-1:0] carry_reg, carry_next;
    logic [CCNT_W-1:0]  ccnt_reg, ccnt_next;
    phase_t             phase_reg, phase_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [1:0]         hits_reg, hits_next;
    logic               lastw_reg;

    logic               pend_valid_reg;
    result_t            pend_reg;
    logic               out_valid_reg;
    result_t            out_reg;
    logic               out_last_reg;

    logic [REM_W-1:0]   need;
    logic [CAT_W-1:0]   cat;
    logic [CAT_W-1:0]   tok_cat;
    logic [CAT_W-1:0]   rest_cat;
    logic               empty_tok, full_tok, tok_valid;
    logic [WORD_W-1:0]  tok32;
    logic [REM_W-1:0]   consume;
    logic               res_gen;
    result_t            new_res;
    logic               out_free;
    logic               trunc_gen;
    logic               push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= '0;
            end_reg    <= '0;
            hpat_reg   <= '0;
            hmask_reg  <= '0;
            hshift_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START_PATTERN:  start_reg  <= cfg_data;
                REG_END_PATTERN:    end_reg    <= cfg_data;
                REG_HEADER_PATTERN: hpat_reg   <= cfg_data;
                REG_HEADER_MASK:    hmask_reg  <= cfg_data;
                REG_HEADER_SHIFT:   hshift_reg <= cfg_data[SHIFT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // The unconsumed bits sit at the top of word_reg, the carried bits just above them.
    assign need     = REM_W'(TOKEN_BITS) - REM_W'(ccnt_reg);
    assign cat      = {carry_reg, word_reg};
    assign tok_cat  = cat >> (REM_W'(WORD_W) - need);
    assign rest_cat = cat >> (REM_W'(WORD_W) - rem_reg);
    assign empty_tok = (ccnt_reg == '0) && !word_reg[WORD_W-1];
    assign full_tok  = !empty_tok && (rem_reg >= need);
    assign tok_valid = empty_tok || full_tok;
    assign tok32     = empty_tok ? '0 : WORD_W'(tok_cat[TOKEN_BITS-1:0]);

    always_comb
    begin
        if (empty_tok)
        begin
            consume = REM_W'(1);
        end
        else if (full_tok)
        begin
            consume = need;
        end
        else
        begin
            consume = rem_reg;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        hits_next  = hits_reg;
        carry_next = tok_valid ? '0 : rest_cat[CARRY_W-1:0];
        ccnt_next  = tok_valid ? '0 : CCNT_W'(ccnt_reg + CCNT_W'(rem_reg));
        res_gen    = 1'b0;
        new_res    = '{kind: KIND_OK, column: col_reg, row: '0, pixel_word: '0};
        if (tok_valid)
        begin
            priority case (phase_reg)
                PH_START:
                begin
                    if (tok32 != WORD_W'(start_reg))
                    begin
                        res_gen = 1'b1;
                        new_res.kind = KIND_BAD_START;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_HEADER;
                        col_next = '0;
                    end
                end
                PH_HEADER:
                begin
                    if ((tok32 & ~WORD_W'(hmask_reg) & TOK_MASK) != WORD_W'(hpat_reg))
                    begin
                        res_gen = 1'b1;
                        new_res.kind = KIND_BAD_HEADER;
                        phase_next = PH_DONE;
                    end
                    else if (((tok32 & WORD_W'(hmask_reg)) >> hshift_reg) != WORD_W'(col_reg))
                    begin
                        res_gen = 1'b1;
                        new_res.kind = KIND_WRONG_COLUMN;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_ROW;
                        row_next = '0;
                    end
                end
                PH_ROW:
                begin
                    if (tok32 != '0 && hits_reg < MAX_HITS)
                    begin
                        res_gen = 1'b1;
                        new_res.kind = KIND_HIT;
                        new_res.row = row_reg;
                        new_res.pixel_word = tok32[PIX_W-1:0];
                        hits_next = hits_reg + 2'd1;
                    end
                    if (row_reg >= ROW_LAST)
                    begin
                        row_next = '0;
                        if (col_reg >= COL_LAST)
                        begin
                            phase_next = PH_END;
                        end
                        else
                        begin
                            col_next = col_reg + COL_W'(1);
                            phase_next = PH_HEADER;
                        end
                    end
                    else
                    begin
                        row_next = row_reg + ROW_W'(1);
                    end
                end
                PH_END:
                begin
                    res_gen = 1'b1;
                    new_res.kind = (tok32 != WORD_W'(end_reg)) ? KIND_BAD_END : KIND_OK;
                    phase_next = PH_DONE;
                end
                default:
                begin
                end
            endcase
        end
        word_next = word_reg << consume;
        rem_next  = rem_reg - consume;
    end

    assign out_free  = !out_valid_reg || !out_stall;
    assign trunc_gen = lastw_reg && (phase_reg == PH_START || phase_reg == PH_HEADER
                       || phase_reg == PH_ROW || phase_reg == PH_END);
    assign push = pend_valid_reg && ((cmd.step && res_gen) || cmd.trunc || cmd.flush);

    assign st.parse_done = (rem_reg == '0) || phase_reg == PH_IDLE || phase_reg == PH_DONE;
    assign st.res_gen    = res_gen;
    assign st.trunc_gen  = trunc_gen;
    assign st.pend_valid = pend_valid_reg;
    assign st.out_free   = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            carry_reg      <= '0;
            ccnt_reg       <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            hits_reg       <= '0;
            rem_reg        <= '0;
            lastw_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                rem_reg   <= REM_W'(WORD_W);
                hits_reg  <= '0;
                lastw_reg <= frame_last;
                if (frame_first)
                begin
                    phase_reg <= PH_START;
                    carry_reg <= '0;
                    ccnt_reg  <= '0;
                    col_reg   <= '0;
                    row_reg   <= '0;
                end
            end
            else if (cmd.step)
            begin
                rem_reg   <= rem_next;
                phase_reg <= phase_next;
                carry_reg <= (phase_next == PH_DONE) ? '0 : carry_next;
                ccnt_reg  <= (phase_next == PH_DONE) ? '0 : ccnt_next;
                col_reg   <= col_next;
                row_reg   <= row_next;
                hits_reg  <= hits_next;
            end
            else if (cmd.trunc)
            begin
                phase_reg <= PH_DONE;
                carry_reg <= '0;
                ccnt_reg  <= '0;
            end

            if ((cmd.step && res_gen) || cmd.trunc)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            word_reg <= word_data;
        end
        else if (cmd.step)
        begin
            word_reg <= word_next;
        end

        if (cmd.step && res_gen)
        begin
            pend_reg <= new_res;
        end
        else if (cmd.trunc)
        begin
            pend_reg <= '{kind: KIND_TRUNCATED, column: col_reg, row: '0, pixel_word: '0};
        end

        if (push)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= cmd.flush;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;
    assign out_last  = out_last_reg;

    a_hits_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        hits_reg <= MAX_HITS)
        else $error("more hits than slots in one item");
    a_carry_short: assert property (@(posedge clk) disable iff (!rst_n)
        ccnt_reg < CCNT_W'(TOKEN_BITS))
        else $error("carry holds a whole token");
    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |=> !pend_valid_reg && out_valid_reg && out_last_reg)
        else $error("flush did not deliver the final result");

endmodule

[design/zero_suppressed_frame_decoder.sv]
// Channel  Handshake            Payload
// input    in_valid / in_stall  word_data, frame_first, frame_last
// output   out_valid/out_stall  kind, column, row, pixel_word, last
// config   cfg_we               cfg_index, cfg_data
//
// Each item is loaded, then parsed one token per step (an empty token is one bit,
// so up to 32 tokens per word); the parser then sees the word used up, closes the
// item and hands over its final result. A new item is taken only from idle.
// The token step takes one token per cycle while no stalled output holds it.
// Reset clears the parser to idle and the configuration registers and counters to zero.
// A stalled output holds the parser only when a further result is due.
module zero_suppressed_frame_decoder
    import zsfd_pkg::*;
#(
    parameter int NUM_COLUMNS = 16,
    parameter int NUM_ROWS = 128,
    parameter int TOKEN_BITS = 22
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [WORD_W-1:0]     word_data,
    input  logic                  frame_first,
    input  logic                  frame_last,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            kind,
    output logic [COL_W-1:0]      column,
    output logic [ROW_W-1:0]      row,
    output logic [PIX_W-1:0]      pixel_word,
    output logic                  last
);

    zsfd_cmd_t    cmd;
    zsfd_status_t st;
    result_t      res;

    zsfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    zsfd_datapath #(
        .NUM_COLUMNS (NUM_COLUMNS),
        .NUM_ROWS    (NUM_ROWS),
        .TOKEN_BITS  (TOKEN_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .word_data   (word_data),
        .frame_first (frame_first),
        .frame_last  (frame_last),
        .cmd         (cmd),
        .st          (st),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .out_res     (res),
        .out_last    (last)
    );

    assign kind       = res.kind;
    assign column     = res.column;
    assign row        = res.row;
    assign pixel_word = res.pixel_word;

endmodule
